// ===== rtl/ptwe_pkg.sv =====
// Package with payload types, constants and tables for the polygon transform block.
`timescale 1ns / 1ps
`default_nettype none
package ptwe_pkg;
    localparam int COORD_BITS = 16;
    localparam int CW = 13;
    localparam int ACC_BITS = 26;
    localparam int ZW = 20;
    localparam logic [CW-1:0] WIDTH_RESET = 13'd800;
    localparam logic [CW-1:0] HEIGHT_RESET = 13'd450;
    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [7:0]  vertex_x;
        logic signed [7:0]  vertex_y;
        logic [15:0]        angle;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               last_vertex;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [3:0]         copy_index;
        logic               run_end;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         last;
    } vtx_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                4'd0: r = 20'sd131072;
                4'd1: r = 20'sd77376;
                4'd2: r = 20'sd40884;
                4'd3: r = 20'sd20753;
                4'd4: r = 20'sd10417;
                4'd5: r = 20'sd5213;
                4'd6: r = 20'sd2607;
                4'd7: r = 20'sd1304;
                4'd8: r = 20'sd652;
                4'd9: r = 20'sd326;
                4'd10: r = 20'sd163;
                4'd11: r = 20'sd81;
                4'd12: r = 20'sd41;
                4'd13: r = 20'sd20;
                4'd14: r = 20'sd10;
                default: r = 20'sd5;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        begin
            hi = (34'sd1 <<< (COORD_BITS - 1)) - 34'sd1;
            lo = -hi - 34'sd1;
            if (v > hi) return hi[COORD_BITS-1:0];
            else if (v < lo) return lo[COORD_BITS-1:0];
            else return v[COORD_BITS-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ptwe_xform.sv =====
// Iterative CORDIC rotation, gain, scale and translate of one vertex.
`timescale 1ns / 1ps
`default_nettype none
module ptwe_xform (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ptwe_pkg::in_item_t item,
    output logic                   done,
    output ptwe_pkg::vtx_t         vtx
);
    typedef enum logic [2:0] {S_IDLE, S_ROT, S_GX, S_GY, S_SX, S_SY, S_OUT} state_t;
    localparam int AW = ptwe_pkg::ACC_BITS;

    state_t state_reg;
    logic [3:0] iter_reg;
    logic signed [AW-1:0] x_reg, y_reg;
    logic signed [ptwe_pkg::ZW-1:0] z_reg;
    logic signed [47:0] prod_reg;
    logic signed [40:0] sx_reg, sy_reg;
    ptwe_pkg::in_item_t it_reg;
    logic done_reg;
    ptwe_pkg::vtx_t vtx_reg;

    logic signed [AW-1:0] x0, y0, ys, xs;
    logic signed [AW-1:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [47:0] mul_p;
    logic signed [33:0] rx, ry;

    assign x0 = AW'(signed'(item.vertex_x)) <<< 16;
    assign y0 = AW'(signed'(item.vertex_y)) <<< 16;
    assign ys = y_reg >>> iter_reg;
    assign xs = x_reg >>> iter_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GX: begin mul_a = x_reg; mul_b = 17'sd39797; end
            S_GY: begin mul_a = y_reg; mul_b = 17'sd39797; end
            S_SX: begin mul_a = x_reg; mul_b = signed'({1'b0, it_reg.scale_x}); end
            S_SY: begin mul_a = AW'(prod_reg >>> 16); mul_b = signed'({1'b0, it_reg.scale_y}); end
            default: ;
        endcase
        mul_p = 48'(mul_a) * 48'(mul_b);
    end

    assign rx = 34'(it_reg.pos_x) + 34'((sx_reg + 41'sd8388608) >>> 24);
    assign ry = 34'(it_reg.pos_y) + 34'((sy_reg + 41'sd8388608) >>> 24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_OUT);
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        it_reg <= item;
                        iter_reg <= 4'd0;
                        z_reg <= ptwe_pkg::ZW'({item.angle[13:0], 4'b0});
                        unique case (item.angle[15:14])
                            2'd1: begin x_reg <= -y0; y_reg <= x0; end
                            2'd2: begin x_reg <= -x0; y_reg <= -y0; end
                            2'd3: begin x_reg <= y0; y_reg <= -x0; end
                            default: begin x_reg <= x0; y_reg <= y0; end
                        endcase
                        state_reg <= S_ROT;
                    end
                S_ROT:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - ptwe_pkg::atan_lut(iter_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + ptwe_pkg::atan_lut(iter_reg);
                    end
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15) state_reg <= S_GX;
                end
                S_GX: begin prod_reg <= mul_p; state_reg <= S_GY; end
                S_GY: begin prod_reg <= mul_p; x_reg <= AW'(prod_reg >>> 16);
                            state_reg <= S_SX; end
                S_SX: begin sx_reg <= 41'(mul_p); state_reg <= S_SY; end
                S_SY: begin sy_reg <= 41'(mul_p); state_reg <= S_OUT; end
                S_OUT:
                begin
                    vtx_reg.px <= ptwe_pkg::sat_c(rx);
                    vtx_reg.py <= ptwe_pkg::sat_c(ry);
                    vtx_reg.last <= it_reg.last_vertex;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign vtx = vtx_reg;
endmodule
`default_nettype wire

// ===== rtl/ptwe_edges.sv =====
// Sequencer that emits the nine wrapped copies of each edge.
`timescale 1ns / 1ps
`default_nettype none
module ptwe_edges (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      vtx_valid,
    input  wire ptwe_pkg::vtx_t            vtx,
    input  wire logic [ptwe_pkg::CW-1:0]   width,
    input  wire logic [ptwe_pkg::CW-1:0]   height,
    output logic                           busy,
    output logic                           valid,
    input  wire logic                      stall,
    output ptwe_pkg::out_item_t            data
);
    typedef enum logic [1:0] {E_IDLE, E_EDGE, E_CLOSE} state_t;
    localparam int CB = ptwe_pkg::COORD_BITS;

    state_t state_reg;
    logic have_first_reg, last_reg;
    logic signed [CB-1:0] fx_reg, fy_reg, px_reg, py_reg, cx_reg, cy_reg;
    logic [1:0] dx_reg, dy_reg;
    logic valid_reg;
    ptwe_pkg::out_item_t data_reg;

    logic signed [CB-1:0] ax, ay, bx, by;
    logic signed [33:0] ox, oy;
    logic final_copy, can_load, load;

    always_comb
    begin
        if (state_reg == E_CLOSE)
        begin
            ax = cx_reg; ay = cy_reg; bx = fx_reg; by = fy_reg;
        end
        else
        begin
            ax = px_reg; ay = py_reg; bx = cx_reg; by = cy_reg;
        end
        case (dx_reg)
            2'd0: ox = -34'(width);
            2'd1: ox = 34'sd0;
            default: ox = 34'(width);
        endcase
        case (dy_reg)
            2'd0: oy = -34'(height);
            2'd1: oy = 34'sd0;
            default: oy = 34'(height);
        endcase
    end

    assign final_copy = (dx_reg == 2'd2) && (dy_reg == 2'd2);
    assign can_load = !valid_reg || !stall;
    assign load = ((state_reg == E_EDGE) || (state_reg == E_CLOSE)) && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            have_first_reg <= 1'b0;
            valid_reg <= 1'b0;
            fx_reg <= '0; fy_reg <= '0; px_reg <= '0; py_reg <= '0;
        end
        else
        begin
            if (load) valid_reg <= 1'b1;
            else if (!stall) valid_reg <= 1'b0;
            unique case (state_reg) inside
                E_IDLE:
                    if (vtx_valid)
                    begin
                        cx_reg <= vtx.px; cy_reg <= vtx.py; last_reg <= vtx.last;
                        dx_reg <= 2'd0; dy_reg <= 2'd0;
                        if (!have_first_reg)
                        begin
                            fx_reg <= vtx.px; fy_reg <= vtx.py;
                            px_reg <= vtx.px; py_reg <= vtx.py;
                            have_first_reg <= !vtx.last;
                            if (vtx.last) state_reg <= E_CLOSE;
                        end
                        else
                        begin
                            state_reg <= E_EDGE;
                            if (vtx.last) have_first_reg <= 1'b0;
                        end
                    end
                E_EDGE, E_CLOSE:
                    if (can_load)
                    begin
                        data_reg.start_x <= ptwe_pkg::sat_c(34'(ax) + ox);
                        data_reg.start_y <= ptwe_pkg::sat_c(34'(ay) + oy);
                        data_reg.end_x <= ptwe_pkg::sat_c(34'(bx) + ox);
                        data_reg.end_y <= ptwe_pkg::sat_c(34'(by) + oy);
                        data_reg.copy_index <= 4'(dy_reg) * 4'd3 + 4'(dx_reg);
                        data_reg.run_end <= final_copy &&
                            (state_reg == E_CLOSE || !last_reg);
                        if (final_copy)
                        begin
                            dx_reg <= 2'd0;
                            dy_reg <= 2'd0;
                            if (state_reg == E_EDGE)
                            begin
                                px_reg <= cx_reg;
                                py_reg <= cy_reg;
                            end
                            if (state_reg == E_EDGE && last_reg) state_reg <= E_CLOSE;
                            else state_reg <= E_IDLE;
                        end
                        else if (dx_reg == 2'd2)
                        begin
                            dx_reg <= 2'd0;
                            dy_reg <= dy_reg + 2'd1;
                        end
                        else dx_reg <= dx_reg + 2'd1;
                    end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != E_IDLE) || valid_reg;
    assign valid = valid_reg;
    assign data = data_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && stall |=> valid_reg && $stable(data_reg))
        else $error("output item changed under stall");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.copy_index <= 4'd8)
        else $error("copy index out of range");
    a_run_end_idx: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.run_end |-> data_reg.copy_index == 4'd8)
        else $error("run end on a copy other than the last");
endmodule
`default_nettype wire

// ===== rtl/polygon_transform_wrap_edges.sv =====
// Top level of the polygon transform block with screen-wrap edge copies.
// Input channel in_valid/in_stall carries one vertex item with angle, scale
// and position. The block takes an item only when fully idle; in_stall is high
// while a vertex is being transformed or its edges are still being emitted.
// Each vertex runs through a shared CORDIC and multiplier sequencer: 16 rotation
// steps, four multiply steps, one saturation step and a registered done handoff.
// Then the edge sequencer emits nine items per edge, one per cycle when the
// receiver does not stall, eighteen for a last vertex that is not also first.
// A first vertex that is not last gives no items.
// When out_stall is high the current output item holds and the sequencer waits.
// Configuration writes on cfg_valid/cfg_ready set screen_width (index 0) and
// screen_height (index 1); other indexes are ignored. cfg_ready is always high.
// Reset sets the sizes to 800 by 450 and clears the stored polygon vertices.
`timescale 1ns / 1ps
`default_nettype none
module polygon_transform_wrap_edges (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ptwe_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ptwe_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [12:0]         cfg_data
);
    logic [ptwe_pkg::CW-1:0] width_reg, height_reg;
    logic busy_x_reg;
    logic xf_done, edge_busy, accept;
    ptwe_pkg::vtx_t vtx;

    assign cfg_ready = 1'b1;
    assign in_stall = busy_x_reg || edge_busy;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= ptwe_pkg::WIDTH_RESET;
            height_reg <= ptwe_pkg::HEIGHT_RESET;
            busy_x_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ptwe_pkg::REG_WIDTH: width_reg <= cfg_data;
                    ptwe_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) busy_x_reg <= 1'b1;
            else if (xf_done) busy_x_reg <= 1'b0;
        end
    end

    ptwe_xform u_xform (
        .clk(clk), .rst_n(rst_n), .start(accept), .item(in_data),
        .done(xf_done), .vtx(vtx)
    );

    ptwe_edges u_edges (
        .clk(clk), .rst_n(rst_n), .vtx_valid(xf_done), .vtx(vtx),
        .width(width_reg), .height(height_reg), .busy(edge_busy),
        .valid(out_valid), .stall(out_stall), .data(out_data)
    );
endmodule
`default_nettype wire
